// ===== hw/rtl/pdf_pkg.sv =====
package pdf_pkg;

   localparam int PW = 26;
   localparam int TW = 16;
   localparam int DEPTH_W = 21;
   localparam int TOUT_W = 17;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 18;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   localparam int MUL_W = 34;
   localparam int ACC_W = 2 * MUL_W;

   localparam int DIV_STEPS = 32;
   localparam int DQ_W = 32;
   localparam int DVS_W = 35;
   localparam int REM_W = 36;

   localparam logic signed [MUL_W-1:0] ALPHA_Q16 = 34'sd9830;
   localparam logic signed [MUL_W-1:0] ONE_MINUS_ALPHA_Q16 = 34'sd55706;
   localparam logic signed [MUL_W-1:0] GRAVITY_MICRO = 34'sd980665;
   localparam logic signed [MUL_W-1:0] MM_SCALE = 34'sd100000000;

   localparam logic [PW-1:0] SURFACE_RESET = 26'd1621200;
   localparam logic [10:0] DENSITY_RESET = 11'd997;
   localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 21'sd1048575;
   localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -21'sd1048576;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FLUID_DENSITY = 2'd0,
      REG_DEPTH_OFFSET  = 2'd1,
      REG_TEMP_OFFSET   = 2'd2
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_RD,
      ST_WR,
      ST_MEAN,
      ST_EP1,
      ST_EP2,
      ST_ET1,
      ST_ET2,
      ST_DEN,
      ST_NUM,
      ST_DIVD_GO,
      ST_DIVD_WAIT,
      ST_OUT
   } pdf_state_type;

   typedef struct packed {
      logic             start;
      logic [REM_W-1:0] rem_init;
      logic [DQ_W-1:0]  dq_init;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [DQ_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== hw/rtl/pdf_ram.sv =====
module pdf_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 10
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pdf_divider.sv =====
module pdf_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  pdf_pkg::div_req_type div_req,
   output pdf_pkg::div_rsp_type div_rsp
);

   logic                      busy_ff, busy_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic [pdf_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [pdf_pkg::DQ_W-1:0]  dq_ff, dq_in;
   logic [pdf_pkg::REM_W-1:0] shifted;
   logic                      ge;
   logic                      last_step;

   assign shifted = {rem_ff[pdf_pkg::REM_W-2:0], dq_ff[pdf_pkg::DQ_W-1]};
   assign ge = shifted >= {1'b0, div_req.divisor};
   assign last_step = busy_ff && (cnt_ff == 5'(pdf_pkg::DIV_STEPS - 1));

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dq_in = dq_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = div_req.rem_init;
         dq_in = div_req.dq_init;
      end else if (busy_ff) begin
         rem_in = ge ? shifted - {1'b0, div_req.divisor} : shifted;
         dq_in = {dq_ff[pdf_pkg::DQ_W-2:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dq_ff <= dq_in;
   end

   assign div_rsp.done = last_step;
   assign div_rsp.quotient = dq_ff;

endmodule

// ===== hw/rtl/pressure_depth_filter_unit.sv =====
// flow: each request runs the reciprocal multiply for the window mean, the multiply
// sequence and 32 divider steps before its result is offered
// throughput: one transaction at a time; a new request is taken only once the result is
// loaded into the output register; the first after reset fills the window instead
// reset: synchronous, active high; filters unprimed, surface pressure 101325 Pa,
// registers at density 997 and zero offsets
module pressure_depth_filter_unit #(
   parameter int WINDOW_SIZE = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // pressure_in [25:0], temp_in [41:26], zero fill
   input  logic [pdf_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tare_now
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // depth_mm [20:0], temp_out [37:21], zero fill
   output logic [pdf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [pdf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pdf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int SUM_W = pdf_pkg::PW + $clog2(WINDOW_SIZE);
   localparam logic [AW-1:0] IDX_LAST = AW'(WINDOW_SIZE - 1);
   localparam int MEAN_SHIFT = SUM_W + $clog2(WINDOW_SIZE);
   localparam logic [63:0] MEAN_RECIP =
      ((64'd1 << MEAN_SHIFT) + 64'(WINDOW_SIZE - 1)) / 64'(WINDOW_SIZE);

   pdf_pkg::pdf_state_type state_ff, state_in;

   logic [10:0]                      density_ff, density_in;
   logic [17:0]                      depth_off_ff, depth_off_in;
   logic [12:0]                      temp_off_ff, temp_off_in;

   logic [pdf_pkg::PW-1:0]           p_ff, p_in;
   logic signed [pdf_pkg::TW-1:0]    t_ff, t_in;
   logic                             tare_ff, tare_in;
   logic [AW-1:0]                    fill_ff, fill_in;
   logic [SUM_W-1:0]                 sum_ff, sum_in;
   logic [AW-1:0]                    widx_ff, widx_in;
   logic                             primed_ff, primed_in;
   logic [pdf_pkg::PW-1:0]           pf_ff, pf_in;
   logic signed [pdf_pkg::TW-1:0]    tf_ff, tf_in;
   logic [pdf_pkg::PW-1:0]           surf_ff, surf_in;
   logic signed [pdf_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [pdf_pkg::DVS_W-1:0]        den_ff, den_in;
   logic                             neg_ff, neg_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [pdf_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                             req_accept;
   logic                             fill_last;
   logic                             rsp_load;
   logic [AW-1:0]                    widx_next;
   logic [10:0]                      rho_eff;
   logic signed [pdf_pkg::PW:0]      diff;
   logic [pdf_pkg::PW:0]             diff_abs;

   logic signed [pdf_pkg::MUL_W-1:0] mul_a, mul_b;
   logic signed [pdf_pkg::ACC_W-1:0] prod;
   logic                             mul_accum;

   logic                             ram_wr_en, ram_rd_en;
   logic [AW-1:0]                    ram_wr_addr;
   logic [pdf_pkg::PW-1:0]           ram_rd_data;

   pdf_pkg::div_req_type             div_req;
   pdf_pkg::div_rsp_type             div_rsp;

   logic signed [32:0]               q_signed;
   logic signed [33:0]               depth_sum;
   logic signed [pdf_pkg::DEPTH_W-1:0] depth_sat;
   logic signed [pdf_pkg::TOUT_W-1:0]  temp_out;

   assign req_accept = req_tvalid && req_tready;
   assign fill_last = fill_ff == IDX_LAST;
   assign rsp_load = (state_ff == pdf_pkg::ST_OUT) && (!rsp_valid_ff || rsp_tready);
   assign widx_next = (widx_ff == IDX_LAST) ? '0 : widx_ff + 1'b1;
   assign rho_eff = (density_ff == 11'd0) ? 11'd1 : density_ff;
   assign diff = signed'({1'b0, pf_ff}) - signed'({1'b0, surf_ff});
   assign diff_abs = diff[pdf_pkg::PW] ? unsigned'(-diff) : unsigned'(diff);
   assign prod = mul_a * mul_b;

   pdf_ram #(
      .WIDTH (pdf_pkg::PW),
      .DEPTH (WINDOW_SIZE)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (p_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (widx_ff),
      .rd_data (ram_rd_data)
   );

   pdf_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pdf_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = primed_ff ? pdf_pkg::ST_RD : pdf_pkg::ST_FILL;
            end
         end
         pdf_pkg::ST_FILL: begin
            if (fill_last) begin
               state_in = pdf_pkg::ST_DEN;
            end
         end
         pdf_pkg::ST_RD:      state_in = pdf_pkg::ST_WR;
         pdf_pkg::ST_WR:      state_in = pdf_pkg::ST_MEAN;
         pdf_pkg::ST_MEAN:    state_in = pdf_pkg::ST_EP1;
         pdf_pkg::ST_EP1:     state_in = pdf_pkg::ST_EP2;
         pdf_pkg::ST_EP2:     state_in = pdf_pkg::ST_ET1;
         pdf_pkg::ST_ET1:     state_in = pdf_pkg::ST_ET2;
         pdf_pkg::ST_ET2:     state_in = pdf_pkg::ST_DEN;
         pdf_pkg::ST_DEN:     state_in = pdf_pkg::ST_NUM;
         pdf_pkg::ST_NUM:     state_in = pdf_pkg::ST_DIVD_GO;
         pdf_pkg::ST_DIVD_GO: state_in = pdf_pkg::ST_DIVD_WAIT;
         pdf_pkg::ST_DIVD_WAIT: begin
            if (div_rsp.done) begin
               state_in = pdf_pkg::ST_OUT;
            end
         end
         pdf_pkg::ST_OUT: begin
            if (rsp_load) begin
               state_in = pdf_pkg::ST_IDLE;
            end
         end
         default: state_in = pdf_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = state_ff == pdf_pkg::ST_IDLE;
      ram_wr_en = (state_ff == pdf_pkg::ST_FILL) || (state_ff == pdf_pkg::ST_WR);
      ram_wr_addr = (state_ff == pdf_pkg::ST_FILL) ? fill_ff : widx_ff;
      ram_rd_en = state_ff == pdf_pkg::ST_RD;

      div_req.start = state_ff == pdf_pkg::ST_DIVD_GO;
      div_req.rem_init = pdf_pkg::REM_W'(acc_ff[52:32]);
      div_req.dq_init = acc_ff[31:0];
      div_req.divisor = den_ff;

      mul_accum = 1'b0;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         pdf_pkg::ST_MEAN: begin
            mul_a = signed'({{(pdf_pkg::MUL_W-SUM_W){1'b0}}, sum_ff});
            mul_b = signed'(pdf_pkg::MUL_W'(MEAN_RECIP));
         end
         pdf_pkg::ST_EP1: begin
            mul_a = signed'({{(pdf_pkg::MUL_W-pdf_pkg::PW){1'b0}},
                             acc_ff[MEAN_SHIFT+pdf_pkg::PW-1:MEAN_SHIFT]});
            mul_b = pdf_pkg::ALPHA_Q16;
         end
         pdf_pkg::ST_EP2: begin
            mul_a = signed'({{(pdf_pkg::MUL_W-pdf_pkg::PW){1'b0}}, pf_ff});
            mul_b = pdf_pkg::ONE_MINUS_ALPHA_Q16;
            mul_accum = 1'b1;
         end
         pdf_pkg::ST_ET1: begin
            mul_a = pdf_pkg::MUL_W'(t_ff);
            mul_b = pdf_pkg::ALPHA_Q16;
         end
         pdf_pkg::ST_ET2: begin
            mul_a = pdf_pkg::MUL_W'(tf_ff);
            mul_b = pdf_pkg::ONE_MINUS_ALPHA_Q16;
            mul_accum = 1'b1;
         end
         pdf_pkg::ST_DEN: begin
            mul_a = signed'({{(pdf_pkg::MUL_W-11){1'b0}}, rho_eff});
            mul_b = pdf_pkg::GRAVITY_MICRO;
         end
         pdf_pkg::ST_NUM: begin
            mul_a = signed'({{(pdf_pkg::MUL_W-pdf_pkg::PW-1){1'b0}}, diff_abs});
            mul_b = pdf_pkg::MM_SCALE;
         end
         default: begin
         end
      endcase
   end

   // result formatting
   always_comb begin
      q_signed = neg_ff ? -signed'({1'b0, div_rsp.quotient}) : signed'({1'b0, div_rsp.quotient});
      depth_sum = 34'(q_signed) + 34'(signed'(depth_off_ff));
      if (depth_sum > 34'(pdf_pkg::DEPTH_MAX)) begin
         depth_sat = pdf_pkg::DEPTH_MAX;
      end else if (depth_sum < 34'(pdf_pkg::DEPTH_MIN)) begin
         depth_sat = pdf_pkg::DEPTH_MIN;
      end else begin
         depth_sat = depth_sum[pdf_pkg::DEPTH_W-1:0];
      end
      temp_out = pdf_pkg::TOUT_W'(tf_ff) + pdf_pkg::TOUT_W'(signed'(temp_off_ff));
   end

   // datapath
   always_comb begin
      density_in = density_ff;
      depth_off_in = depth_off_ff;
      temp_off_in = temp_off_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            pdf_pkg::REG_FLUID_DENSITY: density_in = csr_wdata[10:0];
            pdf_pkg::REG_DEPTH_OFFSET:  depth_off_in = csr_wdata;
            pdf_pkg::REG_TEMP_OFFSET:   temp_off_in = csr_wdata[12:0];
            default: begin
            end
         endcase
      end

      p_in = p_ff;
      t_in = t_ff;
      tare_in = tare_ff;
      fill_in = fill_ff;
      sum_in = sum_ff;
      widx_in = widx_ff;
      primed_in = primed_ff;
      pf_in = pf_ff;
      tf_in = tf_ff;
      surf_in = surf_ff;
      acc_in = acc_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         pdf_pkg::ST_IDLE: begin
            if (req_accept) begin
               p_in = req_tdata[pdf_pkg::PW-1:0];
               t_in = signed'(req_tdata[pdf_pkg::PW+pdf_pkg::TW-1:pdf_pkg::PW]);
               tare_in = req_tuser;
               fill_in = '0;
            end
         end
         pdf_pkg::ST_FILL: begin
            fill_in = fill_ff + 1'b1;
            if (fill_last) begin
               // first sample primes window and both filters
               sum_in = SUM_W'(p_ff) * SUM_W'(WINDOW_SIZE);
               widx_in = (WINDOW_SIZE == 1) ? '0 : AW'(1);
               primed_in = 1'b1;
               pf_in = p_ff;
               acc_in = signed'({{(pdf_pkg::ACC_W-pdf_pkg::TW-16){t_ff[pdf_pkg::TW-1]}},
                                 t_ff, 16'b0});
            end
         end
         pdf_pkg::ST_WR: begin
            sum_in = sum_ff - SUM_W'(ram_rd_data) + SUM_W'(p_ff);
            widx_in = widx_next;
         end
         pdf_pkg::ST_MEAN, pdf_pkg::ST_EP1, pdf_pkg::ST_EP2, pdf_pkg::ST_ET2: begin
            acc_in = (mul_accum ? acc_ff : '0) + prod;
         end
         pdf_pkg::ST_ET1: begin
            pf_in = acc_ff[pdf_pkg::PW+15:16];
            acc_in = prod;
         end
         pdf_pkg::ST_DEN: begin
            tf_in = signed'(acc_ff[31:16]);
            if (tare_ff) begin
               surf_in = pf_ff;
            end
            acc_in = prod;
         end
         pdf_pkg::ST_NUM: begin
            den_in = {acc_ff[30:0], 4'b0};
            neg_in = diff[pdf_pkg::PW];
            acc_in = prod;
         end
         pdf_pkg::ST_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {2'b0, temp_out, depth_sat};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdf_pkg::ST_IDLE;
         density_ff <= pdf_pkg::DENSITY_RESET;
         depth_off_ff <= '0;
         temp_off_ff <= '0;
         widx_ff <= '0;
         primed_ff <= 1'b0;
         surf_ff <= pdf_pkg::SURFACE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         density_ff <= density_in;
         depth_off_ff <= depth_off_in;
         temp_off_ff <= temp_off_in;
         widx_ff <= widx_in;
         primed_ff <= primed_in;
         surf_ff <= surf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff <= p_in;
      t_ff <= t_in;
      tare_ff <= tare_in;
      fill_ff <= fill_in;
      sum_ff <= sum_in;
      pf_ff <= pf_in;
      tf_ff <= tf_in;
      acc_ff <= acc_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_widx_range: assert property (@(posedge clock) disable iff (reset)
      widx_ff <= IDX_LAST)
      else $error("window index beyond window");

   a_prime_fill: assert property (@(posedge clock) disable iff (reset)
      req_accept && !primed_ff |=> state_ff == pdf_pkg::ST_FILL)
      else $error("unprimed transaction skipped window fill");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == pdf_pkg::ST_DIVD_WAIT)
      else $error("divider finished outside a wait state");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pdf_pkg::ST_OUT))
      else $error("result raised outside output state");

endmodule
